[rtl/dpf_pkg.sv]
// Package for the DPD pair force core: payload types, register codes,
// fixed-point constants and the pipeline stage map.
// No dependencies; every other file imports it.
package dpf_pkg;

    // Bead types and coefficient table size
    localparam int NUM_TYPES = 2;
    localparam int NUM_COEF  = NUM_TYPES * NUM_TYPES;

    // Fixed-point constants (Q16.16)
    localparam logic [16:0] Q_ONE        = 17'd65536;
    localparam logic [46:0] WIDE_LIMIT   = 47'd1 << 46;
    localparam logic [18:0] DRAG_Q       = 19'd294912;
    localparam logic [20:0] RAND_SCALE_Q = 21'd1482686;
    localparam logic [16:0] RND_BIAS     = 17'd32768;
    localparam logic signed [49:0] LIM50 = 50'sd70368744177664;

    // Register reset values
    localparam logic [30:0] CUTOFF_RESET = 31'd65536;
    localparam logic [31:0] COEF_RESET   = 32'd1638400;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CUTOFF = 3'd0,
        REG_COEF00 = 3'd1,
        REG_COEF01 = 3'd2,
        REG_COEF10 = 3'd3,
        REG_COEF11 = 3'd4
    } cfg_reg_t;

    // Pipeline stage map
    localparam int ST_IN      = 0;
    localparam int ST_MUL     = 1;
    localparam int ST_SUM     = 2;
    localparam int ST_CHK     = 3;
    localparam int SQ_STEPS   = 31;
    localparam int ST_SQ0     = 4;
    localparam int ST_ROOT    = ST_SQ0 + SQ_STEPS;
    localparam int ST_DIV0    = ST_ROOT + 1;
    localparam int QS_BITS    = 17;
    localparam int QL_BITS    = 47;
    localparam int ST_OMUL    = ST_DIV0;
    localparam int ST_OSHIFT  = ST_DIV0 + 1;
    localparam int ST_Q       = ST_DIV0 + QS_BITS;
    localparam int ST_CMUL    = ST_Q + 1;
    localparam int ST_CON     = ST_Q + 2;
    localparam int ST_VCLAMP  = ST_DIV0 + QL_BITS;
    localparam int ST_WMUL    = ST_VCLAMP + 1;
    localparam int ST_WADD1   = ST_VCLAMP + 2;
    localparam int ST_WADD2   = ST_VCLAMP + 3;
    localparam int ST_WCLAMP  = ST_VCLAMP + 4;
    localparam int ST_DMUL    = ST_VCLAMP + 5;
    localparam int ST_DADD    = ST_VCLAMP + 6;
    localparam int ST_DCLAMP  = ST_VCLAMP + 7;
    localparam int ST_SSUM    = ST_VCLAMP + 8;
    localparam int ST_SSAT    = ST_VCLAMP + 9;
    localparam int ST_FMUL    = ST_VCLAMP + 10;
    localparam int ST_FADD    = ST_VCLAMP + 11;
    localparam int ST_FOUT    = ST_VCLAMP + 12;
    localparam int ST_LAST    = ST_FOUT;

    // Channel payloads
    typedef struct packed {
        logic signed [31:0] disp_x;
        logic signed [31:0] disp_y;
        logic signed [31:0] disp_z;
        logic signed [31:0] relvel_x;
        logic signed [31:0] relvel_y;
        logic signed [31:0] relvel_z;
        logic [31:0]        id_a;
        logic [31:0]        id_b;
        logic               type_a;
        logic               type_b;
        logic [31:0]        step_random;
    } pair_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               interacting;
    } result_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] value;
    } cfg_word_t;

    // Context carried down the pipeline
    typedef struct packed {
        logic [2:0][31:0] dmag;
        logic [2:0]       dneg;
        logic [2:0][31:0] vmag;
        logic [2:0]       vneg;
        logic [31:0]      id_a;
        logic [31:0]      id_b;
        logic [31:0]      step;
        logic             ta;
        logic             tb;
        logic [2:0][63:0] sq;
        logic [2:0][63:0] pdv;
        logic [61:0]      rc2;
        logic [31:0]      h0;
        logic [31:0]      h1;
        logic [63:0]      d2;
        logic [49:0]      dvs;
        logic [31:0]      h;
        logic             live;
        logic [46:0]      dv_mag;
        logic             dv_neg;
        logic [36:0]      kprod;
        logic             rnd_neg;
        logic [20:0]      kmag;
        logic [61:0]      sx;
        logic [61:0]      sres;
        logic [30:0]      r;
        logic [30:0]      om_mag;
        logic             om_neg;
        logic [61:0]      wprod;
        logic [51:0]      rprod;
        logic             ran_neg;
        logic [45:0]      wd;
        logic [35:0]      ran_mag;
        logic [46:0]      trem;
        logic [16:0]      tq;
        logic [2:0][47:0] urem;
        logic [2:0][16:0] uq;
        logic [62:0]      vrem;
        logic [46:0]      vq;
        logic             vovf;
        logic [16:0]      q;
        logic [48:0]      cprod;
        logic             con_neg;
        logic [49:0]      con_w;
        logic [46:0]      vr_mag;
        logic             vr_neg;
        logic [46:0]      pw0;
        logic [45:0]      pw1;
        logic [46:0]      pw2;
        logic [45:0]      pw3;
        logic [70:0]      s1;
        logic [70:0]      s2;
        logic [93:0]      acc;
        logic [46:0]      x_mag;
        logic             x_neg;
        logic [42:0]      pd0;
        logic [41:0]      pd1;
        logic [66:0]      dsum;
        logic [46:0]      drag_mag;
        logic             drag_neg;
        logic [49:0]      ssum;
        logic [46:0]      s_mag;
        logic             s_neg;
        logic [2:0][40:0] pf0;
        logic [2:0][39:0] pf1;
        logic [2:0][64:0] fsum;
        logic [2:0][31:0] fout;
    } ctx_t;

endpackage

[rtl/dpf_if.sv]
// Channel interfaces of the DPD pair force core: pair, result and config.
// Depends on dpf_pkg for the payload types.
interface dpf_pair_if;
    import dpf_pkg::*;
    logic  valid;
    logic  ready;
    pair_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dpf_result_if;
    import dpf_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dpf_cfg_if;
    import dpf_pkg::*;
    logic      valid;
    logic      ready;
    cfg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/dpd_pair_force_core.sv]
// DPD pair force core: pipelined conservative, drag and random pair force.
// Depends on dpf_pkg and the channel interfaces in dpf_if.sv.
//
//  channel  dir  word        contents
//  cfg      in   cfg_word_t  register index and value
//  pair     in   pair_t      displacement, relative velocity, ids, types, step word
//  result   out  result_t    force x/y/z and interacting flag
//
// One pair enters per cycle unless the pipeline stalls; the core has 96 pipeline
// stages and the output register. The depth is set by the one-bit-per-stage square
// root (31 stages) and the 47-stage radial velocity divider.
// Reset clears stage valid bits and loads the register defaults.
// A stall freezes the pipeline only when the last stage and the output
// register are both full; bubbles keep draining otherwise.
module dpd_pair_force_core (
    input  logic          clk,
    input  logic          rst_n,
    dpf_cfg_if.sink       cfg,
    dpf_pair_if.sink      pair,
    dpf_result_if.source  result
);
    import dpf_pkg::*;

    logic [30:0] cutoff_reg;
    logic [31:0] coef_reg [NUM_COEF];

    ctx_t            ctx_reg [ST_LAST+1];
    logic [ST_LAST:0] vld_reg;
    ctx_t            ctx_in;
    logic            stage_en;
    logic            out_valid_reg;
    result_t         out_data_reg;
    logic            out_load;

    // Take every config word
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= CUTOFF_RESET;
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= COEF_RESET;
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.data.index))
                REG_CUTOFF: cutoff_reg  <= cfg.data.value[30:0];
                REG_COEF00: coef_reg[0] <= cfg.data.value;
                REG_COEF01: coef_reg[1] <= cfg.data.value;
                REG_COEF10: coef_reg[2] <= cfg.data.value;
                REG_COEF11: coef_reg[3] <= cfg.data.value;
                default: ;
            endcase
        end
    end

    // Advance unless the last stage and the output register are both held
    assign stage_en   = !vld_reg[ST_LAST] || !out_valid_reg || result.ready;
    assign out_load   = !out_valid_reg || result.ready;
    assign pair.ready = stage_en;

    // Split input word into magnitudes and signs
    always_comb
    begin
        ctx_in         = '0;
        ctx_in.dneg[0] = pair.data.disp_x[31];
        ctx_in.dneg[1] = pair.data.disp_y[31];
        ctx_in.dneg[2] = pair.data.disp_z[31];
        ctx_in.vneg[0] = pair.data.relvel_x[31];
        ctx_in.vneg[1] = pair.data.relvel_y[31];
        ctx_in.vneg[2] = pair.data.relvel_z[31];
        ctx_in.dmag[0] = pair.data.disp_x[31] ? -pair.data.disp_x : pair.data.disp_x;
        ctx_in.dmag[1] = pair.data.disp_y[31] ? -pair.data.disp_y : pair.data.disp_y;
        ctx_in.dmag[2] = pair.data.disp_z[31] ? -pair.data.disp_z : pair.data.disp_z;
        ctx_in.vmag[0] = pair.data.relvel_x[31] ? -pair.data.relvel_x : pair.data.relvel_x;
        ctx_in.vmag[1] = pair.data.relvel_y[31] ? -pair.data.relvel_y : pair.data.relvel_y;
        ctx_in.vmag[2] = pair.data.relvel_z[31] ? -pair.data.relvel_z : pair.data.relvel_z;
        ctx_in.id_a    = pair.data.id_a;
        ctx_in.id_b    = pair.data.id_b;
        ctx_in.step    = pair.data.step_random;
        ctx_in.ta      = pair.data.type_a;
        ctx_in.tb      = pair.data.type_b;
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[ST_IN] <= 1'b0;
        end
        else if (stage_en)
        begin
            vld_reg[ST_IN] <= pair.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            ctx_reg[ST_IN] <= ctx_in;
        end
    end

    // Pipeline stages; each applies the steps scheduled at its index
    for (genvar k = 1; k <= ST_LAST; k++)
    begin : g_stage
        localparam int SQ_SH = (k >= ST_SQ0 && k < ST_SQ0 + SQ_STEPS) ?
                               2 * (ST_SQ0 + SQ_STEPS - 1 - k) : 0;
        localparam int SB = (k >= ST_DIV0 && k < ST_DIV0 + QS_BITS) ?
                            ST_DIV0 + QS_BITS - 1 - k : 0;
        localparam int LB = (k >= ST_DIV0 && k < ST_DIV0 + QL_BITS) ?
                            ST_DIV0 + QL_BITS - 1 - k : 0;

        ctx_t ctx_next;

        always_comb
        begin : b_step
            ctx_t        c;
            logic [49:0] dvs;
            logic [49:0] term;
            logic [16:0] rnd_val;
            logic [15:0] rmag;
            logic [61:0] bitv;
            logic [62:0] trial;
            logic [47:0] dsh;
            logic [47:0] ush;
            logic [77:0] lsh;
            logic [31:0] coef;
            logic [31:0] amag;
            logic [77:0] xr;
            logic [50:0] dr;
            logic [49:0] ranw;
            logic [49:0] dragw;
            logic [48:0] fm;

            c       = ctx_reg[k-1];
            dvs     = '0;
            term    = '0;
            rnd_val = '0;
            rmag    = '0;
            bitv    = 62'd1 << SQ_SH;
            trial   = '0;
            dsh     = 48'(cutoff_reg) << SB;
            ush     = 48'(c.r) << SB;
            lsh     = 78'(c.r) << LB;
            coef    = coef_reg[{c.ta, c.tb}];
            amag    = '0;
            xr      = '0;
            dr      = '0;
            ranw    = '0;
            dragw   = '0;
            fm      = '0;

            // Squares, dot-product terms, cutoff square, hash products
            if (k == ST_MUL)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    c.sq[i]  = 64'(c.dmag[i]) * 64'(c.dmag[i]);
                    c.pdv[i] = 64'(c.dmag[i]) * 64'(c.vmag[i]);
                end
                c.rc2 = 62'(cutoff_reg) * 62'(cutoff_reg);
                c.h0  = (c.id_a ^ c.step) * c.id_b;
                c.h1  = (c.id_b ^ c.step) * c.id_a;
            end

            // Sum distance square, dot product and hash
            if (k == ST_SUM)
            begin
                c.d2 = c.sq[0] + c.sq[1] + c.sq[2];
                for (int i = 0; i < 3; i++)
                begin
                    term = 50'(c.pdv[i] >> 16);
                    dvs  = (c.dneg[i] ^ c.vneg[i]) ? dvs - term : dvs + term;
                end
                c.dvs = dvs;
                c.h   = c.h0 + c.h1;
            end

            // Cutoff test, dot product saturation, random scale, root setup
            if (k == ST_CHK)
            begin
                c.live = (c.d2 != 64'd0) && (c.d2 <= 64'(c.rc2));
                if ($signed(c.dvs) > LIM50)
                begin
                    c.dv_mag = WIDE_LIMIT;
                    c.dv_neg = 1'b0;
                end
                else if ($signed(c.dvs) < -LIM50)
                begin
                    c.dv_mag = WIDE_LIMIT;
                    c.dv_neg = 1'b1;
                end
                else
                begin
                    c.dv_neg = c.dvs[49];
                    c.dv_mag = 47'(c.dvs[49] ? -c.dvs : c.dvs);
                end
                rnd_val   = 17'(c.h[31:16]) - RND_BIAS;
                c.rnd_neg = rnd_val[16];
                rmag      = 16'(rnd_val[16] ? -rnd_val : rnd_val);
                c.kprod   = 37'(RAND_SCALE_Q) * 37'(rmag);
                c.sx      = c.d2[61:0];
                c.sres    = '0;
            end

            if (k == ST_SQ0)
            begin
                c.kmag = 21'(c.kprod >> 16);
            end

            // One root bit per stage
            if (k >= ST_SQ0 && k < ST_SQ0 + SQ_STEPS)
            begin
                trial = 63'(c.sres) + 63'(bitv);
                if (63'(c.sx) >= trial)
                begin
                    c.sx   = c.sx - 62'(trial);
                    c.sres = (c.sres >> 1) + bitv;
                end
                else
                begin
                    c.sres = c.sres >> 1;
                end
            end

            // Take the root; set up dividers and 1 - r
            if (k == ST_ROOT)
            begin
                c.r      = 31'(c.sres);
                c.om_neg = c.r > 31'(Q_ONE);
                c.om_mag = c.om_neg ? c.r - 31'(Q_ONE) : 31'(Q_ONE) - c.r;
                c.trem   = {c.r, 16'd0};
                c.tq     = '0;
                for (int i = 0; i < 3; i++)
                begin
                    c.urem[i] = {c.dmag[i], 16'd0};
                    c.uq[i]   = '0;
                end
                c.vovf = 31'(c.dv_mag >> 31) >= c.r;
                c.vrem = {c.dv_mag, 16'd0};
                c.vq   = '0;
            end

            // Weight square and random term products
            if (k == ST_OMUL)
            begin
                c.wprod   = 62'(c.om_mag) * 62'(c.om_mag);
                c.rprod   = 52'(c.kmag) * 52'(c.om_mag);
                c.ran_neg = c.rnd_neg ^ c.om_neg;
            end

            if (k == ST_OSHIFT)
            begin
                c.wd      = 46'(c.wprod >> 16);
                c.ran_mag = 36'(c.rprod >> 16);
            end

            // r/rc and unit vector dividers, one quotient bit per stage
            if (k >= ST_DIV0 && k < ST_DIV0 + QS_BITS)
            begin
                if (48'(c.trem) >= dsh)
                begin
                    c.trem  = c.trem - 47'(dsh);
                    c.tq[SB] = 1'b1;
                end
                for (int i = 0; i < 3; i++)
                begin
                    if (c.urem[i] >= ush)
                    begin
                        c.urem[i]   = c.urem[i] - ush;
                        c.uq[i][SB] = 1'b1;
                    end
                end
            end

            // Radial velocity divider
            if (k >= ST_DIV0 && k < ST_DIV0 + QL_BITS)
            begin
                if (78'(c.vrem) >= lsh)
                begin
                    c.vrem   = c.vrem - 63'(lsh);
                    c.vq[LB] = 1'b1;
                end
            end

            // Conservative term
            if (k == ST_Q)
            begin
                c.q = (c.tq >= Q_ONE) ? 17'd0 : Q_ONE - c.tq;
            end

            if (k == ST_CMUL)
            begin
                c.con_neg = coef[31];
                amag      = coef[31] ? -coef : coef;
                c.cprod   = 49'(amag) * 49'(c.q);
            end

            if (k == ST_CON)
            begin
                c.con_w = c.con_neg ? -50'(c.cprod >> 16) : 50'(c.cprod >> 16);
            end

            // Drag: clamp radial velocity, multiply by weight in parts
            if (k == ST_VCLAMP)
            begin
                c.vr_mag = (c.vovf || c.vq > WIDE_LIMIT) ? WIDE_LIMIT : c.vq;
                c.vr_neg = c.dv_neg;
            end

            if (k == ST_WMUL)
            begin
                c.pw0 = 47'(c.wd[22:0])  * 47'(c.vr_mag[23:0]);
                c.pw1 = 46'(c.wd[22:0])  * 46'(c.vr_mag[46:24]);
                c.pw2 = 47'(c.wd[45:23]) * 47'(c.vr_mag[23:0]);
                c.pw3 = 46'(c.wd[45:23]) * 46'(c.vr_mag[46:24]);
            end

            if (k == ST_WADD1)
            begin
                c.s1 = 71'(c.pw0) + (71'(c.pw1) << 24);
                c.s2 = 71'(c.pw2) + (71'(c.pw3) << 24);
            end

            if (k == ST_WADD2)
            begin
                c.acc = 94'(c.s1) + (94'(c.s2) << 23);
            end

            if (k == ST_WCLAMP)
            begin
                xr      = 78'(c.acc >> 16);
                c.x_mag = (xr > 78'(WIDE_LIMIT)) ? WIDE_LIMIT : 47'(xr);
                c.x_neg = c.vr_neg;
            end

            if (k == ST_DMUL)
            begin
                c.pd0 = 43'(c.x_mag[23:0])  * 43'(DRAG_Q);
                c.pd1 = 42'(c.x_mag[46:24]) * 42'(DRAG_Q);
            end

            if (k == ST_DADD)
            begin
                c.dsum = 67'(c.pd0) + (67'(c.pd1) << 24);
            end

            if (k == ST_DCLAMP)
            begin
                dr         = 51'(c.dsum >> 16);
                c.drag_mag = (dr > 51'(WIDE_LIMIT)) ? WIDE_LIMIT : 47'(dr);
                c.drag_neg = !c.x_neg;
            end

            // Sum the three scalar terms and saturate
            if (k == ST_SSUM)
            begin
                ranw   = c.ran_neg ? -50'(c.ran_mag) : 50'(c.ran_mag);
                dragw  = c.drag_neg ? -50'(c.drag_mag) : 50'(c.drag_mag);
                c.ssum = c.con_w - ranw + dragw;
            end

            if (k == ST_SSAT)
            begin
                if ($signed(c.ssum) > LIM50)
                begin
                    c.s_mag = WIDE_LIMIT;
                    c.s_neg = 1'b0;
                end
                else if ($signed(c.ssum) < -LIM50)
                begin
                    c.s_mag = WIDE_LIMIT;
                    c.s_neg = 1'b1;
                end
                else
                begin
                    c.s_neg = c.ssum[49];
                    c.s_mag = 47'(c.ssum[49] ? -c.ssum : c.ssum);
                end
            end

            // Project onto the unit vector
            if (k == ST_FMUL)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    c.pf0[i] = 41'(c.uq[i]) * 41'(c.s_mag[23:0]);
                    c.pf1[i] = 40'(c.uq[i]) * 40'(c.s_mag[46:24]);
                end
            end

            if (k == ST_FADD)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    c.fsum[i] = 65'(c.pf0[i]) + (65'(c.pf1[i]) << 24);
                end
            end

            // Saturate to 32 bits; drop force outside the cutoff
            if (k == ST_FOUT)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    fm = 49'(c.fsum[i] >> 16);
                    if (!c.live)
                    begin
                        c.fout[i] = '0;
                    end
                    else if (c.dneg[i] ^ c.s_neg)
                    begin
                        c.fout[i] = (fm > 49'h80000000) ? 32'h80000000 : -32'(fm);
                    end
                    else
                    begin
                        c.fout[i] = (fm > 49'h7fffffff) ? 32'h7fffffff : 32'(fm);
                    end
                end
            end

            ctx_next = c;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (stage_en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_en)
            begin
                ctx_reg[k] <= ctx_next;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= vld_reg[ST_LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.force_x     <= ctx_reg[ST_LAST].fout[0];
            out_data_reg.force_y     <= ctx_reg[ST_LAST].fout[1];
            out_data_reg.force_z     <= ctx_reg[ST_LAST].fout[2];
            out_data_reg.interacting <= ctx_reg[ST_LAST].live;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> pair.ready)
        else $error("pair not taken while output register is empty");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.data.interacting |->
            result.data.force_x == 32'sd0 && result.data.force_y == 32'sd0 &&
            result.data.force_z == 32'sd0)
        else $error("force nonzero on a pair that does not interact");

    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_ROOT] && ctx_reg[ST_ROOT].live |-> ctx_reg[ST_ROOT].r != 31'd0)
        else $error("zero root on an interacting pair");

    a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_LAST] && !stage_en |=>
            vld_reg[ST_LAST] && $stable(ctx_reg[ST_LAST].fout))
        else $error("last stage changed during a stall");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for dpd_pair_force_core: streams bead pairs, predicts
// each force word in fixed point and compares it with what the core returns.
// Depends on dpf_pkg and the channel interfaces of the RTL.
module tb_top;
    import dpf_pkg::*;

    localparam int          LATENCY_WAIT = 120;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [2:0]  REG_NONE     = 3'd7;
    localparam logic [63:0] CAP          = 64'd1 << 46;

    logic clk;
    logic rst_n;

    dpf_cfg_if    cfg_ch ();
    dpf_pair_if   pair_ch ();
    dpf_result_if res_ch ();

    dpd_pair_force_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .pair   (pair_ch.sink),
        .result (res_ch.source)
    );

    // Register shadow and expected force words
    logic [30:0] cut_rc;
    longint      coef_tab [4];
    result_t     force_expect_q [$];

    int errors;
    int pairs_sent;
    int words_seen;
    int hits_seen;
    int burst_left;
    int cycles;

    always #6 clk = ~clk;

    // Magnitude product, truncated and capped like the datapath
    function automatic longint fx_mul(longint a, longint b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] prod;
        logic [63:0]  m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        prod = {64'd0, ma} * {64'd0, mb};
        if (prod[127:64] != 0)
        begin
            m = CAP;
        end
        else
        begin
            m = prod[63:0] >> 16;
            if (m > CAP)
                m = CAP;
        end
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint fx_div(longint a, logic [63:0] d);
        logic [63:0] m;
        m = (((a < 0) ? -a : a) << 16) / d;
        if (m > CAP)
            m = CAP;
        return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_wide(longint a);
        if (a > longint'(CAP))
            return longint'(CAP);
        if (a < -longint'(CAP))
            return -longint'(CAP);
        return a;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Sum of conservative, drag and random force for one pair
    function automatic result_t pair_force(pair_t p);
        result_t     f;
        longint      d [3];
        longint      v [3];
        logic [63:0] d2;
        logic [63:0] rc2;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] q;
        logic [31:0] h;
        longint      aij, con, om, wd, dv, vr, drag, rnd, ran, s, fi;
        f = '0;
        d[0] = longint'($signed(p.disp_x));
        d[1] = longint'($signed(p.disp_y));
        d[2] = longint'($signed(p.disp_z));
        v[0] = longint'($signed(p.relvel_x));
        v[1] = longint'($signed(p.relvel_y));
        v[2] = longint'($signed(p.relvel_z));
        d2 = 0;
        for (int i = 0; i < 3; i++)
            d2 += 64'((d[i] < 0) ? -d[i] : d[i]) * 64'((d[i] < 0) ? -d[i] : d[i]);
        rc2 = 64'(cut_rc) * 64'(cut_rc);
        if (d2 == 0 || d2 > rc2)
            return f;
        r = int_sqrt(d2);
        aij = coef_tab[{p.type_a, p.type_b}];
        t = (r << 16) / 64'(cut_rc);
        q = (t >= 64'(Q_ONE)) ? 64'd0 : 64'(Q_ONE) - t;
        con = fx_mul(aij, longint'(q));
        om = longint'(Q_ONE) - longint'(r);
        wd = fx_mul(om, om);
        dv = 0;
        for (int i = 0; i < 3; i++)
            dv += fx_mul(d[i], v[i]);
        dv = clamp_wide(dv);
        vr = fx_div(dv, r);
        drag = -fx_mul(longint'(DRAG_Q), fx_mul(wd, vr));
        h = ((p.id_a ^ p.step_random) * p.id_b) + ((p.id_b ^ p.step_random) * p.id_a);
        rnd = longint'(h >> 16) - longint'(RND_BIAS);
        ran = fx_mul(fx_mul(longint'(RAND_SCALE_Q), rnd), om);
        s = clamp_wide(con - ran + drag);
        for (int i = 0; i < 3; i++)
        begin
            fi = fx_mul(fx_div(d[i], r), s);
            if (fi > 64'sd2147483647)
                fi = 64'sd2147483647;
            if (fi < -64'sd2147483648)
                fi = -64'sd2147483648;
            if (i == 0)
                f.force_x = fi[31:0];
            else if (i == 1)
                f.force_y = fi[31:0];
            else
                f.force_z = fi[31:0];
        end
        f.interacting = 1'b1;
        return f;
    endfunction

    // Send one pair; bursts of random length separated by random gaps
    task automatic send_pair(pair_t p);
        if (burst_left == 0)
        begin
            if ($urandom_range(3) != 0)
            begin
                pair_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
        end
        pair_ch.valid <= 1'b1;
        pair_ch.data  <= p;
        @(posedge clk);
        while (!pair_ch.ready)
            @(posedge clk);
        force_expect_q.push_back(pair_force(p));
        pairs_sent++;
        burst_left--;
    endtask

    // Drop valid and hold until every expected word has come back
    task automatic drain;
        pair_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (force_expect_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.value <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_CUTOFF)
            cut_rc = val[30:0];
        else if (idx >= REG_COEF00 && idx <= REG_COEF11)
            coef_tab[idx - REG_COEF00] = longint'($signed(val));
        @(posedge clk);
    endtask

    task automatic write_all(logic [30:0] rc, logic [31:0] c0, logic [31:0] c1,
                             logic [31:0] c2, logic [31:0] c3);
        drain();
        write_reg(REG_CUTOFF, {1'b0, rc});
        write_reg(REG_COEF00, c0);
        write_reg(REG_COEF01, c1);
        write_reg(REG_COEF10, c2);
        write_reg(REG_COEF11, c3);
    endtask

    function automatic logic [31:0] span_val(int unsigned span);
        int signed m;
        m = $urandom_range(span);
        return ($urandom_range(1) != 0) ? -m : m;
    endfunction

    // Mostly pairs inside the cutoff with random content; some raw noise
    function automatic pair_t rand_pair();
        pair_t       p;
        int unsigned span;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, 2'($urandom), $urandom};
        if ($urandom_range(4) != 0)
        begin
            span = (cut_rc / 2 > 1) ? cut_rc / 2 : 1;
            p.disp_x = span_val(span);
            p.disp_y = span_val(span);
            p.disp_z = span_val(span);
            if ($urandom_range(2) != 0)
            begin
                p.relvel_x = span_val(200000);
                p.relvel_y = span_val(200000);
                p.relvel_z = span_val(200000);
            end
        end
        return p;
    endfunction

    function automatic pair_t mk_pair(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                      logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
        pair_t p;
        p = {dx, dy, dz, vx, vy, vz, $urandom, $urandom, 2'($urandom), $urandom};
        return p;
    endfunction

    // Reset defaults: coincident beads, the exact cutoff, just beyond it
    task automatic test_reset_defaults;
        send_pair(mk_pair(0, 0, 0, 32'h7fffffff, 32'h80000000, 5));
        send_pair(mk_pair(65536, 0, 0, 1000, 0, 0));
        send_pair(mk_pair(65537, 0, 0, 1000, 0, 0));
        send_pair(mk_pair(0, 0, 32'hffff0000, 0, 0, 70000));
        send_pair(mk_pair(1, 0, 0, 0, 0, 0));
        send_pair(mk_pair(20000, 30000, 32'hffff8000, 32'h80000000, 32'h7fffffff,
                          32'h80000000));
    endtask

    // Every type pair, extreme ids and step words, and a write to an unused index
    task automatic test_types_and_ids;
        pair_t p;
        write_all(31'd65536, 32'h80000000, 32'h7fffffff, 32'd0, 32'hfff00000);
        for (int i = 0; i < 4; i++)
        begin
            p = mk_pair(30000, 32'hffffc000, 100, 5000, 6000, 32'hffff0000);
            {p.type_a, p.type_b} = 2'(i);
            p.id_a = (i[0]) ? 32'hffffffff : 32'd0;
            p.id_b = (i[1]) ? 32'hffffffff : 32'd1;
            p.step_random = (i < 2) ? 32'hffffffff : 32'd0;
            send_pair(p);
        end
        drain();
        write_reg(REG_NONE, 32'h12345678);
        send_pair(mk_pair(10, 10, 10, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    endtask

    // Saturation with the widest cutoff and a zero cutoff
    task automatic test_extremes;
        write_all(31'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_pair(mk_pair(32'h7fffffff, 0, 0, 32'h80000000, 0, 0));
        send_pair(mk_pair(32'h80000001, 0, 0, 32'h7fffffff, 32'h7fffffff, 0));
        send_pair(mk_pair(32'h40000000, 32'hc0000000, 32'h40000000, 0, 0, 0));
        send_pair(mk_pair(32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 1));
        write_all(31'd0, 32'd1638400, 32'd1638400, 32'd1638400, 32'd1638400);
        send_pair(mk_pair(0, 0, 0, 0, 0, 0));
        send_pair(mk_pair(1, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random(int n, logic [30:0] rc);
        write_all(rc, $urandom, $urandom, $urandom, $urandom);
        repeat (n)
            send_pair(rand_pair());
    endtask

    // Compare each returned word with the oldest expectation
    always @(posedge clk)
    begin
        result_t e;
        result_t a;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            a = res_ch.data;
            words_seen++;
            if (force_expect_q.size() == 0)
            begin
                $error("unexpected result word %h", a);
                errors++;
            end
            else
            begin
                e = force_expect_q.pop_front();
                if (e.interacting)
                    hits_seen++;
                if (a.force_x !== e.force_x)
                begin
                    $error("force_x expected %h got %h", e.force_x, a.force_x);
                    errors++;
                end
                if (a.force_y !== e.force_y)
                begin
                    $error("force_y expected %h got %h", e.force_y, a.force_y);
                    errors++;
                end
                if (a.force_z !== e.force_z)
                begin
                    $error("force_z expected %h got %h", e.force_z, a.force_z);
                    errors++;
                end
                if (a.interacting !== e.interacting)
                begin
                    $error("interacting expected %b got %b", e.interacting, a.interacting);
                    errors++;
                end
            end
        end
    end

    // Receiver stall: switch between always ready, a rotating mask and coin flips
    always @(posedge clk)
    begin
        logic [15:0] mask;
        int          mode;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            mask = 16'hb5a3;
            mode = 0;
        end
        else
        begin
            if ((cycles % 300) == 0)
            begin
                mode = $urandom_range(2);
                mask = $urandom;
            end
            mask = {mask[14:0], mask[15]};
            if (mode == 0)
                res_ch.ready <= 1'b1;
            else if (mode == 1)
                res_ch.ready <= mask[0];
            else
                res_ch.ready <= $urandom_range(1);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        pair_ch.valid = 1'b0;
        pair_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        errors = 0;
        pairs_sent = 0;
        words_seen = 0;
        hits_seen = 0;
        burst_left = 0;
        cycles = 0;
        cut_rc = CUTOFF_RESET;
        for (int i = 0; i < NUM_COEF; i++)
            coef_tab[i] = longint'($signed(COEF_RESET));
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_types_and_ids();
        test_extremes();
        test_random(250, 31'd65536);
        test_random(120, 31'd200);
        test_random(120, 31'h7fffffff);
        test_random(60, 31'd0);
        test_random(100, 31'($urandom_range(1, 1 << 24)));
        drain();

        $display("Sent %0d pairs, checked %0d words, %0d of them interacting.",
                 pairs_sent, words_seen, hits_seen);
        $display("Covered reset values, eight register settings and saturation cases.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
